// ===== hw/rtl/md5sh_pkg.sv =====
package md5sh_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_MARK = 8'h80;

   // word slots of the block that take the bit length
   localparam logic [3:0] LEN_WORD_LO = 4'd14;
   localparam logic [3:0] LEN_WORD_HI = 4'd15;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ITEM_WORD,
      ITEM_FINISH
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [2:0]    nbytes;
      logic [31:0]   word;
      logic [63:0]   bit_len;
   } q_entry_type;

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROUND_S [0:15] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] i;
      logic [3:0] g;
      i = rnd[3:0];
      case (rnd[5:4])
         2'd0:    g = i;
         2'd1:    g = i * 4'd5 + 4'd1;
         2'd2:    g = i * 4'd3 + 4'd5;
         default: g = i * 4'd7;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] byte_swap(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

// ===== hw/rtl/md5sh_front.sv =====
module md5sh_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   output md5sh_pkg::q_entry_type push_entry,
   output logic                   push_en,
   input  logic                   push_ready
);
   import md5sh_pkg::*;

   logic [31:0] part_ff, part_in;
   logic [1:0]  lane_ff, lane_in;
   logic [63:0] bits_ff, bits_in;
   logic        accept;
   logic [31:0] word_cur;
   logic [63:0] bits_cur;

   assign req_tready = push_ready;
   assign accept = req_tvalid && push_ready;

   always_comb begin
      word_cur = part_ff;
      if (req_tuser) begin
         word_cur[{lane_ff, 3'b000} +: 8] = req_tdata;
      end
      bits_cur = bits_ff + (req_tuser ? 64'd8 : 64'd0);
   end

   assign push_en = accept && (req_tlast || (req_tuser && lane_ff == 2'd3));
   assign push_entry.kind = req_tlast ? ITEM_FINISH : ITEM_WORD;
   assign push_entry.nbytes = {1'b0, lane_ff} + {2'b00, req_tuser};
   assign push_entry.word = word_cur;
   assign push_entry.bit_len = bits_cur;

   always_comb begin
      part_in = part_ff;
      lane_in = lane_ff;
      bits_in = bits_ff;
      if (accept) begin
         part_in = word_cur;
         if (req_tlast) begin
            lane_in = 2'd0;
            bits_in = 64'd0;
         end else if (req_tuser) begin
            lane_in = lane_ff + 2'd1;
            bits_in = bits_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= 2'd0;
         bits_ff <= 64'd0;
      end else begin
         lane_ff <= lane_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

endmodule

// ===== hw/rtl/md5sh_queue.sv =====
module md5sh_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_en,
   input  md5sh_pkg::q_entry_type push_entry,
   output logic                   push_ready,
   input  logic                   pop_en,
   output md5sh_pkg::q_entry_type head,
   output logic                   head_valid
);
   import md5sh_pkg::*;

   localparam logic [QUEUE_CW-1:0] QUEUE_FULL = QUEUE_CW'(QUEUE_DEPTH);

   q_entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]       count_ff, count_in;

   assign push_ready = count_ff != QUEUE_FULL;
   assign head_valid = count_ff != '0;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_en) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_AW'(1);
      end
      if (pop_en) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_AW'(1);
      end
      if (push_en && !pop_en) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/md5sh_back.sv =====
module md5sh_back (
   input  logic                   clock,
   input  logic                   reset,
   input  md5sh_pkg::q_entry_type head,
   input  logic                   head_valid,
   output logic                   pop_en,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [127:0]           rsp_tdata
);
   import md5sh_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   state_type    state_ff, state_in;
   logic [3:0]   widx_ff, widx_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         mark_ff, mark_in;
   logic         final_ff, final_in;
   logic         padding_ff, padding_in;
   logic [31:0]  chain_ff [4];
   logic [31:0]  chain_in [4];
   logic         out_valid_ff, out_valid_in;
   logic [127:0] out_data_ff, out_data_in;
   logic [31:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [63:0]  len_ff, len_in;
   logic [31:0]  msg_ff [16];

   logic         wr_en;
   logic [31:0]  wr_word;
   logic [31:0]  marked_word;
   logic [31:0]  f_val;
   logic [31:0]  round_sum;
   logic [63:0]  rot_wide;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   // message word with the pad byte placed after the last message byte
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (3'(j) < head.nbytes) begin
            marked_word[8*j +: 8] = head.word[8*j +: 8];
         end else if (3'(j) == head.nbytes) begin
            marked_word[8*j +: 8] = PAD_MARK;
         end else begin
            marked_word[8*j +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      round_sum = a_ff + f_val + ROUND_K[rnd_ff] + msg_ff[msg_index(rnd_ff)];
      rot_wide = {round_sum, round_sum} << ROUND_S[{rnd_ff[5:4], rnd_ff[1:0]}];
   end

   always_comb begin
      state_in = state_ff;
      widx_in = widx_ff;
      rnd_in = rnd_ff;
      mark_in = mark_ff;
      final_in = final_ff;
      padding_in = padding_ff;
      chain_in = chain_ff;
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      len_in = len_ff;
      pop_en = 1'b0;
      wr_en = 1'b0;
      wr_word = 32'h0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (head_valid) begin
               pop_en = 1'b1;
               wr_en = 1'b1;
               if (head.kind == ITEM_WORD) begin
                  wr_word = head.word;
               end else begin
                  padding_in = 1'b1;
                  len_in = head.bit_len;
                  state_in = ST_PAD;
                  if (head.nbytes[2]) begin
                     wr_word = head.word;
                     mark_in = 1'b1;
                  end else begin
                     wr_word = marked_word;
                     final_in = widx_ff < LEN_WORD_LO;
                  end
               end
            end
         end
         ST_PAD: begin
            wr_en = 1'b1;
            if (mark_ff) begin
               wr_word = {24'h0, PAD_MARK};
               mark_in = 1'b0;
               final_in = widx_ff < LEN_WORD_LO;
            end else if (final_ff && widx_ff == LEN_WORD_LO) begin
               wr_word = len_ff[31:0];
            end else if (final_ff && widx_ff == LEN_WORD_HI) begin
               wr_word = len_ff[63:32];
            end
         end
         ST_ROUND: begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = b_ff + rot_wide[63:32];
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            if (!padding_ff) begin
               state_in = ST_LOAD;
            end else if (final_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
               final_in = !mark_ff;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in = {byte_swap(chain_ff[2]), byte_swap(chain_ff[3]),
                              byte_swap(chain_ff[0]), byte_swap(chain_ff[1])};
               chain_in[0] = INIT_A;
               chain_in[1] = INIT_B;
               chain_in[2] = INIT_C;
               chain_in[3] = INIT_D;
               padding_in = 1'b0;
               final_in = 1'b0;
               mark_in = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (wr_en) begin
         widx_in = widx_ff + 4'd1;
         if (widx_ff == LEN_WORD_HI) begin
            state_in = ST_ROUND;
            rnd_in = 6'd0;
            a_in = chain_ff[0];
            b_in = chain_ff[1];
            c_in = chain_ff[2];
            d_in = chain_ff[3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         widx_ff <= 4'd0;
         rnd_ff <= 6'd0;
         mark_ff <= 1'b0;
         final_ff <= 1'b0;
         padding_ff <= 1'b0;
         chain_ff[0] <= INIT_A;
         chain_ff[1] <= INIT_B;
         chain_ff[2] <= INIT_C;
         chain_ff[3] <= INIT_D;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         widx_ff <= widx_in;
         rnd_ff <= rnd_in;
         mark_ff <= mark_in;
         final_ff <= final_in;
         padding_ff <= padding_in;
         chain_ff <= chain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      len_ff <= len_in;
      if (wr_en) begin
         msg_ff[widx_ff] <= wr_word;
      end
   end

endmodule

// ===== hw/rtl/md5_stream_hasher.sv =====
// channel  dir  beat contents (lsb up)
// req      in   tdata: data_byte | tuser: byte_valid | tlast: last
// rsp      out  tdata: digest_high, digest_low
//
// bytes are taken one per cycle while the four-entry word queue has room
// each 64-byte block is loaded as 16 words, then takes 64 rounds and a fold
// in the back end; the single round unit sets the sustained byte rate
// end of message adds one or two padding blocks and an output state that loads the digest
// reset is synchronous, active high; no clearing pass is needed
// one digest can wait in the output register while the next message hashes;
// a second finished digest holds the back end until rsp takes the first

module md5_stream_hasher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // byte_valid
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // digest_high, digest_low
);
   import md5sh_pkg::*;

   q_entry_type push_entry;
   logic        push_en;
   logic        push_ready;
   q_entry_type head;
   logic        head_valid;
   logic        pop_en;

   md5sh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_entry (push_entry),
      .push_en    (push_en),
      .push_ready (push_ready)
   );

   md5sh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_en     (pop_en),
      .head       (head),
      .head_valid (head_valid)
   );

   md5sh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop_en     (pop_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // end of message always reaches the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |-> push_en)
      else $error("last beat accepted without a queue entry");

   assert property (@(posedge clock) disable iff (reset)
      pop_en |-> head_valid)
      else $error("queue popped while empty");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("digest valid right after reset");

endmodule
